// File: hdl/pgs_pkg.sv
// ----------------------------------------------------------------------------
// Polar Gaussian sampler package
// Field widths, fixed-point constants, the controller state type and the
// request and status bundles of the serial divider.
// ----------------------------------------------------------------------------
package pgs_pkg;

   // Field widths
   localparam int U_W      = 16;
   localparam int MEAN_W   = 24;
   localparam int SCALE_W  = 16;
   localparam int SAMPLE_W = 24;
   localparam int NORM_W   = 16;

   // Fixed-point formats
   localparam int FRAC_BITS  = 12;
   localparam int PROD_SHIFT = 56 - 2 * FRAC_BITS;

   // Uniform full scale and its square
   localparam logic [U_W-1:0] U_MAX    = 16'hFFFF;
   localparam logic [32:0]    U_MAX_SQ = 33'd4294836225;

   // ln(2) in Q0.32
   localparam logic [31:0] LN2_Q32 = 32'd2977044472;

   // Saturation limits
   localparam logic [31:0]        SAT_NORM = 32'd32767;
   localparam logic signed [25:0] OUT_MAX  = 26'sd8388607;
   localparam logic signed [25:0] OUT_MIN  = -26'sd8388608;

   // Serial divider geometry
   localparam int DIV_REM_W = 61;
   localparam int DIV_D_W   = 60;
   localparam int DIV_Q_W   = 33;
   localparam int STEP_W    = 6;
   localparam logic [STEP_W-1:0] V_STEPS = 6'd31;
   localparam logic [STEP_W-1:0] R_STEPS = 6'd33;

   // Iteration counts of the log and square-root loops
   localparam logic [4:0] LOG_STEPS  = 5'd16;
   localparam logic [4:0] ROOT_STEPS = 5'd16;

   // Controller states
   typedef enum logic [16:0] {
      ST_IDLE  = 17'b00000000000000001,
      ST_SQR   = 17'b00000000000000010,
      ST_CHK   = 17'b00000000000000100,
      ST_DIVV  = 17'b00000000000001000,
      ST_VSQ   = 17'b00000000000010000,
      ST_SUM   = 17'b00000000000100000,
      ST_NORM  = 17'b00000000001000000,
      ST_LOG   = 17'b00000000010000000,
      ST_TLN   = 17'b00000000100000000,
      ST_DIVR  = 17'b00000001000000000,
      ST_MULLO = 17'b00000010000000000,
      ST_MULHI = 17'b00000100000000000,
      ST_MADD  = 17'b00001000000000000,
      ST_ROOT  = 17'b00010000000000000,
      ST_SIGN  = 17'b00100000000000000,
      ST_SCALE = 17'b01000000000000000,
      ST_EMIT  = 17'b10000000000000000
   } state_type;

   // Divider request and status
   typedef struct packed {
      logic                 start;
      logic [STEP_W-1:0]    steps;
      logic [DIV_REM_W-1:0] dividend;
      logic [DIV_D_W-1:0]   divisor;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [DIV_Q_W-1:0] quotient;
   } div_sts_type;

endpackage

// File: hdl/pgs_ifs.sv
// ----------------------------------------------------------------------------
// Polar Gaussian sampler channels
// Valid/ready channels for the uniform pair request and the sample response.
// ----------------------------------------------------------------------------
interface pgs_req_if;
   logic                                valid;
   logic                                ready;
   logic [pgs_pkg::U_W-1:0]             uniform_a;
   logic [pgs_pkg::U_W-1:0]             uniform_b;
   logic signed [pgs_pkg::MEAN_W-1:0]   mean;
   logic [pgs_pkg::SCALE_W-1:0]         scale;

   modport source (output valid, uniform_a, uniform_b, mean, scale, input ready);
   modport sink   (input valid, uniform_a, uniform_b, mean, scale, output ready);
endinterface

interface pgs_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [pgs_pkg::SAMPLE_W-1:0] sample;

   modport source (output valid, sample, input ready);
   modport sink   (input valid, sample, output ready);
endinterface

// File: hdl/pgs_div.sv
// ----------------------------------------------------------------------------
// Polar Gaussian sampler serial divider
// Restoring division, one quotient bit per cycle. Each step compares the
// partial remainder with the divisor, subtracts when it fits and shifts.
// ----------------------------------------------------------------------------
module pgs_div (
   input  logic                 clock,
   input  logic                 reset,
   input  pgs_pkg::div_req_type div_req,
   output pgs_pkg::div_sts_type div_sts
);
   import pgs_pkg::*;

   logic [DIV_REM_W-1:0] rem_ff, rem_in;
   logic [DIV_D_W-1:0]   d_ff, d_in;
   logic [DIV_Q_W-1:0]   q_ff, q_in;
   logic [STEP_W-1:0]    cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic                 ge;
   logic [DIV_REM_W-1:0] rsub;

   // One compare and subtract step
   always_comb begin
      ge   = rem_ff >= DIV_REM_W'(d_ff);
      rsub = ge ? rem_ff - DIV_REM_W'(d_ff) : rem_ff;
   end

   // Load, iterate or hold
   always_comb begin
      rem_in  = rem_ff;
      d_in    = d_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         rem_in  = div_req.dividend;
         d_in    = div_req.divisor;
         q_in    = '0;
         cnt_in  = div_req.steps;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = {rsub[DIV_REM_W-2:0], 1'b0};
         q_in    = {q_ff[DIV_Q_W-2:0], ge};
         cnt_in  = cnt_ff - 1'b1;
         busy_in = cnt_ff != 6'd1;
         done_in = cnt_ff == 6'd1;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      d_ff   <= d_in;
      q_ff   <= q_in;
   end

   assign div_sts.done     = done_ff;
   assign div_sts.quotient = q_ff;

endmodule

// File: hdl/polar_gaussian_sampler_top.sv
// ----------------------------------------------------------------------------
// Polar Gaussian sampler
// Marsaglia polar method in fixed point, worked through bit-serial units.
//
// A request transfer on req_ch carries two uniforms, a mean and a scale.
// In the fresh-pair phase the pair is mapped to V1, V2 and S is formed.
// A pair with S outside (0, 1) is dropped: no response, phase unchanged,
// and the block goes back to idle, ready for the next request.
// An accepted pair yields one sample on rsp_ch and caches the second
// normal value. The next request ignores its uniforms and returns the
// cached value with its own scale and mean.
// A fresh pair is worked through the serial divider (four passes of 31
// or 33 steps), the normalize shift (up to 59 steps), the 16-step log
// loop and two 16-step square roots.
// One request is in work at a time; req_ch.ready is high only when idle.
// The response sits in an output register. While the receiver stalls, the
// register keeps its sample, the block may accept and work one more
// request, and then it waits with that result and ready low until the
// register frees.
// Reset clears the phase, the cache and the response valid.
// ----------------------------------------------------------------------------
module polar_gaussian_sampler_top (
   input logic      clock,
   input logic      reset,
   pgs_req_if.sink  req_ch,
   pgs_rsp_if.source rsp_ch
);
   import pgs_pkg::*;

   state_type            state_ff, state_in;
   logic                 phase_ff, phase_in;
   logic                 comp_ff, comp_in;
   logic [U_W-1:0]       a_mag_ff, a_mag_in, b_mag_ff, b_mag_in;
   logic                 a_neg_ff, a_neg_in, b_neg_ff, b_neg_in;
   logic signed [MEAN_W-1:0] mean_ff, mean_in;
   logic [SCALE_W-1:0]   scale_ff, scale_in;
   logic [31:0]          a2_ff, a2_in, b2_ff, b2_in;
   logic [29:0]          v1_ff, v1_in, v2_ff, v2_in;
   logic [59:0]          s1_ff, s1_in, s2_ff, s2_in, s_ff, s_in;
   logic [59:0]          norm_ff, norm_in;
   logic [5:0]           k_ff, k_in;
   logic [30:0]          m_ff, m_in;
   logic [15:0]          f_ff, f_in;
   logic [4:0]           cnt_ff, cnt_in;
   logic [30:0]          t_ff, t_in;
   logic [46:0]          pp_lo_ff, pp_lo_in;
   logic [47:0]          pp_hi_ff, pp_hi_in;
   logic [31:0]          x_ff, x_in, res_ff, res_in, bit_ff, bit_in;
   logic signed [NORM_W-1:0] n1_ff, n1_in, cache_ff, cache_in;
   logic signed [NORM_W-1:0] emit_n_ff, emit_n_in;
   logic signed [31:0]   p_ff, p_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_sample_ff, rsp_sample_in;

   div_req_type          div_req;
   div_sts_type          div_sts;

   logic [16:0]          two_a, two_b;
   logic [32:0]          sq_sum;
   logic [60:0]          s_sum;
   logic [59:0]          s_clamp;
   logic [61:0]          m_sq;
   logic [31:0]          m_next;
   logic [21:0]          lq;
   logic [53:0]          lq_prod;
   logic [63:0]          qt_sum;
   logic [32:0]          root_try;
   logic [14:0]          mag_sat;
   logic signed [NORM_W-1:0] n_val;
   logic [31:0]          p_mag, p_rnd;
   logic [31-FRAC_BITS:0] r_mag;
   logic signed [25:0]   r_signed, r_sum;
   logic signed [SAMPLE_W-1:0] sample_sat;

   // Serial divider shared by the V and ratio divisions
   pgs_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_sts (div_sts)
   );

   // Map uniforms to signed-magnitude V numerators
   always_comb begin
      two_a = {req_ch.uniform_a, 1'b0};
      two_b = {req_ch.uniform_b, 1'b0};
   end

   // Acceptance test, sum clamp, log mantissa squaring, log scaling, product sum and root trial
   always_comb begin
      sq_sum  = {1'b0, a2_ff} + {1'b0, b2_ff};
      s_sum   = {1'b0, s1_ff} + {1'b0, s2_ff};
      if (s_sum == '0) begin
         s_clamp = 60'd1;
      end else if (s_sum[60]) begin
         s_clamp = {60{1'b1}};
      end else begin
         s_clamp = s_sum[59:0];
      end
      m_sq    = m_ff * m_ff;
      m_next  = m_sq[61:30];
      lq      = {k_ff + 6'd1, 16'd0} - 22'(f_ff);
      lq_prod = lq * LN2_Q32;
      qt_sum  = 64'(pp_lo_ff) + {pp_hi_ff, 16'd0};
      root_try = {1'b0, res_ff} + {1'b0, bit_ff};
   end

   // Saturated, signed normal value from the square root
   always_comb begin
      mag_sat = (res_ff > SAT_NORM) ? SAT_NORM[14:0] : res_ff[14:0];
      if (comp_ff ? b_neg_ff : a_neg_ff) begin
         n_val = -$signed({1'b0, mag_sat});
      end else begin
         n_val = $signed({1'b0, mag_sat});
      end
   end

   // Scale rounding, mean offset and output saturation
   always_comb begin
      p_mag    = p_ff[31] ? 32'(-p_ff) : 32'(p_ff);
      p_rnd    = p_mag + (32'd1 << (FRAC_BITS - 1));
      r_mag    = p_rnd[31:FRAC_BITS];
      r_signed = p_ff[31] ? -$signed(26'(r_mag)) : $signed(26'(r_mag));
      r_sum    = r_signed + 26'(mean_ff);
      if (r_sum > OUT_MAX) begin
         sample_sat = OUT_MAX[SAMPLE_W-1:0];
      end else if (r_sum < OUT_MIN) begin
         sample_sat = OUT_MIN[SAMPLE_W-1:0];
      end else begin
         sample_sat = r_sum[SAMPLE_W-1:0];
      end
   end

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      comp_in       = comp_ff;
      a_mag_in      = a_mag_ff;
      b_mag_in      = b_mag_ff;
      a_neg_in      = a_neg_ff;
      b_neg_in      = b_neg_ff;
      mean_in       = mean_ff;
      scale_in      = scale_ff;
      a2_in         = a2_ff;
      b2_in         = b2_ff;
      v1_in         = v1_ff;
      v2_in         = v2_ff;
      s1_in         = s1_ff;
      s2_in         = s2_ff;
      s_in          = s_ff;
      norm_in       = norm_ff;
      k_in          = k_ff;
      m_in          = m_ff;
      f_in          = f_ff;
      cnt_in        = cnt_ff;
      t_in          = t_ff;
      pp_lo_in      = pp_lo_ff;
      pp_hi_in      = pp_hi_ff;
      x_in          = x_ff;
      res_in        = res_ff;
      bit_in        = bit_ff;
      n1_in         = n1_ff;
      cache_in      = cache_ff;
      emit_n_in     = emit_n_ff;
      p_in          = p_ff;
      rsp_sample_in = rsp_sample_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ch.ready;

      div_req.start    = 1'b0;
      div_req.steps    = V_STEPS;
      div_req.dividend = DIV_REM_W'(a_mag_ff);
      div_req.divisor  = DIV_D_W'(U_MAX);

      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               a_neg_in = ~req_ch.uniform_a[U_W-1];
               b_neg_in = ~req_ch.uniform_b[U_W-1];
               a_mag_in = a_neg_in ? 16'(17'(U_MAX) - two_a) : 16'(two_a - 17'(U_MAX));
               b_mag_in = b_neg_in ? 16'(17'(U_MAX) - two_b) : 16'(two_b - 17'(U_MAX));
               mean_in  = req_ch.mean;
               scale_in = req_ch.scale;
               if (phase_ff) begin
                  emit_n_in = cache_ff;
                  phase_in  = 1'b0;
                  state_in  = ST_SCALE;
               end else begin
                  state_in = ST_SQR;
               end
            end
         end
         ST_SQR: begin
            a2_in    = a_mag_ff * a_mag_ff;
            b2_in    = b_mag_ff * b_mag_ff;
            state_in = ST_CHK;
         end
         ST_CHK: begin
            if (sq_sum >= U_MAX_SQ || (a_mag_ff == '0 && b_mag_ff == '0)) begin
               state_in = ST_IDLE;
            end else begin
               div_req.start = 1'b1;
               comp_in       = 1'b0;
               state_in      = ST_DIVV;
            end
         end
         ST_DIVV: begin
            if (div_sts.done) begin
               if (!comp_ff) begin
                  v1_in            = div_sts.quotient[29:0];
                  div_req.start    = 1'b1;
                  div_req.dividend = DIV_REM_W'(b_mag_ff);
                  comp_in          = 1'b1;
               end else begin
                  v2_in    = div_sts.quotient[29:0];
                  state_in = ST_VSQ;
               end
            end
         end
         ST_VSQ: begin
            s1_in    = v1_ff * v1_ff;
            s2_in    = v2_ff * v2_ff;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            s_in     = s_clamp;
            norm_in  = s_clamp;
            k_in     = '0;
            state_in = ST_NORM;
         end
         ST_NORM: begin
            // Shift the leading one up to the top bit, counting the shifts
            if (norm_ff[59]) begin
               m_in     = norm_ff[59:29];
               f_in     = '0;
               cnt_in   = LOG_STEPS;
               state_in = ST_LOG;
            end else begin
               norm_in = {norm_ff[58:0], 1'b0};
               k_in    = k_ff + 6'd1;
            end
         end
         ST_LOG: begin
            // One fraction bit of log2 per squaring
            if (m_next[31]) begin
               m_in = m_next[31:1];
               f_in = {f_ff[14:0], 1'b1};
            end else begin
               m_in = m_next[30:0];
               f_in = {f_ff[14:0], 1'b0};
            end
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == 5'd1) begin
               state_in = ST_TLN;
            end
         end
         ST_TLN: begin
            t_in             = lq_prod[53:23];
            div_req.start    = 1'b1;
            div_req.steps    = R_STEPS;
            div_req.dividend = DIV_REM_W'(s1_ff);
            div_req.divisor  = s_ff;
            comp_in          = 1'b0;
            state_in         = ST_DIVR;
         end
         ST_DIVR: begin
            if (div_sts.done) begin
               state_in = ST_MULLO;
            end
         end
         ST_MULLO: begin
            pp_lo_in = div_sts.quotient[15:0] * t_ff;
            state_in = ST_MULHI;
         end
         ST_MULHI: begin
            pp_hi_in = div_sts.quotient[32:16] * t_ff;
            state_in = ST_MADD;
         end
         ST_MADD: begin
            x_in     = qt_sum[PROD_SHIFT +: 32];
            res_in   = '0;
            bit_in   = 32'd1 << 30;
            cnt_in   = ROOT_STEPS;
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            // One result bit of the integer square root per cycle
            if ({1'b0, x_ff} >= root_try) begin
               x_in   = 32'(33'(x_ff) - root_try);
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == 5'd1) begin
               state_in = ST_SIGN;
            end
         end
         ST_SIGN: begin
            if (!comp_ff) begin
               n1_in            = n_val;
               div_req.start    = 1'b1;
               div_req.steps    = R_STEPS;
               div_req.dividend = DIV_REM_W'(s2_ff);
               div_req.divisor  = s_ff;
               comp_in          = 1'b1;
               state_in         = ST_DIVR;
            end else begin
               cache_in  = n_val;
               phase_in  = 1'b1;
               emit_n_in = n1_ff;
               state_in  = ST_SCALE;
            end
         end
         ST_SCALE: begin
            p_in     = $signed(32'(emit_n_ff)) * $signed({16'd0, scale_ff});
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            // Wait for the output register to free up
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_sample_in = sample_sat;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= 1'b0;
         comp_ff      <= 1'b0;
         cnt_ff       <= '0;
         cache_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         comp_ff      <= comp_in;
         cnt_ff       <= cnt_in;
         cache_ff     <= cache_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      a_mag_ff      <= a_mag_in;
      b_mag_ff      <= b_mag_in;
      a_neg_ff      <= a_neg_in;
      b_neg_ff      <= b_neg_in;
      mean_ff       <= mean_in;
      scale_ff      <= scale_in;
      a2_ff         <= a2_in;
      b2_ff         <= b2_in;
      v1_ff         <= v1_in;
      v2_ff         <= v2_in;
      s1_ff         <= s1_in;
      s2_ff         <= s2_in;
      s_ff          <= s_in;
      norm_ff       <= norm_in;
      k_ff          <= k_in;
      m_ff          <= m_in;
      f_ff          <= f_in;
      t_ff          <= t_in;
      pp_lo_ff      <= pp_lo_in;
      pp_hi_ff      <= pp_hi_in;
      x_ff          <= x_in;
      res_ff        <= res_in;
      bit_ff        <= bit_in;
      n1_ff         <= n1_in;
      emit_n_ff     <= emit_n_in;
      p_ff          <= p_in;
      rsp_sample_ff <= rsp_sample_in;
   end

   // Channel outputs
   assign req_ch.ready  = state_ff == ST_IDLE;
   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.sample = rsp_sample_ff;

   // The divider only finishes while the sequencer waits for it
   assert property (@(posedge clock) disable iff (reset)
      div_sts.done |-> (state_ff == ST_DIVV || state_ff == ST_DIVR))
      else $error("divider finished outside a wait state");

   // A cached-phase request goes straight to scaling
   assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready && phase_ff) |=> state_ff == ST_SCALE)
      else $error("cached sample not scaled at once");

   // The cache is only written when a fresh pair sets the phase
   assert property (@(posedge clock) disable iff (reset)
      !$stable(cache_ff) |-> (phase_ff && !$past(phase_ff)))
      else $error("cache changed without a fresh pair");

endmodule
